FILE: hw/rtl/dhd_pkg.sv
// dhd_pkg: shared types and constants for the detection head decoder.
// Used by every module under hw/rtl; depends on nothing.
package dhd_pkg;

  localparam int unsigned CfgAddrW  = 5;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned ScoreW    = 16;
  localparam int unsigned ClassW    = 8;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned SizeW     = 13;
  localparam int unsigned PadW      = 10;
  // model-space corner in Q.5, product in Q.17, clamped Q.17 value
  localparam int unsigned CornerW   = 18;
  localparam int unsigned ProdW     = 35;
  localparam int unsigned ClampW    = 29;
  localparam int unsigned FracShift = 17;
  localparam logic [CoordW-1:0] CoordMax = 12'd4095;

  typedef enum logic [2:0] {
    RegScoreThreshold = 3'd0,
    RegInverseScale   = 3'd1,
    RegPadLeft        = 3'd2,
    RegPadTop         = 3'd3,
    RegImageWidth     = 3'd4,
    RegImageHeight    = 3'd5
  } dhd_reg_e;

  typedef struct packed {
    logic [ScoreW-1:0] score_threshold;
    logic [15:0]       inverse_scale;
    logic [PadW-1:0]   pad_left;
    logic [PadW-1:0]   pad_top;
    logic [SizeW-1:0]  image_width;
    logic [SizeW-1:0]  image_height;
  } dhd_cfg_t;

  typedef struct packed {
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic signed [15:0] box_width;
    logic signed [15:0] box_height;
    logic [ScoreW-1:0]  class_score;
    logic               last_class;
  } dhd_in_t;

  typedef struct packed {
    logic [ClassW-1:0] class_id;
    logic [ScoreW-1:0] best_score;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
  } dhd_out_t;

  // argmax verdict for the word just accepted
  typedef struct packed {
    logic              keep;
    logic [ClassW-1:0] class_id;
    logic [ScoreW-1:0] best;
  } dhd_anchor_t;

endpackage

FILE: hw/rtl/dhd_cfg.sv
// dhd_cfg: APB register file for threshold, scale, padding and image size.
// Depends on dhd_pkg.
module dhd_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dhd_pkg::CfgAddrW-1:0]    paddr,
  input  logic [dhd_pkg::CfgDataW-1:0]    pwdata,
  output logic [dhd_pkg::CfgDataW-1:0]    prdata,
  output logic                            pready,
  output dhd_pkg::dhd_cfg_t               cfg_o
);

  dhd_pkg::dhd_cfg_t cfg_q, cfg_d;
  dhd_pkg::dhd_reg_e reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = dhd_pkg::dhd_reg_e'(paddr[dhd_pkg::CfgAddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        dhd_pkg::RegScoreThreshold: cfg_d.score_threshold = pwdata[15:0];
        dhd_pkg::RegInverseScale:   cfg_d.inverse_scale   = pwdata[15:0];
        dhd_pkg::RegPadLeft:        cfg_d.pad_left        = pwdata[dhd_pkg::PadW-1:0];
        dhd_pkg::RegPadTop:         cfg_d.pad_top         = pwdata[dhd_pkg::PadW-1:0];
        dhd_pkg::RegImageWidth:     cfg_d.image_width     = pwdata[dhd_pkg::SizeW-1:0];
        dhd_pkg::RegImageHeight:    cfg_d.image_height    = pwdata[dhd_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      dhd_pkg::RegScoreThreshold: prdata = 32'(cfg_q.score_threshold);
      dhd_pkg::RegInverseScale:   prdata = 32'(cfg_q.inverse_scale);
      dhd_pkg::RegPadLeft:        prdata = 32'(cfg_q.pad_left);
      dhd_pkg::RegPadTop:         prdata = 32'(cfg_q.pad_top);
      dhd_pkg::RegImageWidth:     prdata = 32'(cfg_q.image_width);
      dhd_pkg::RegImageHeight:    prdata = 32'(cfg_q.image_height);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_threshold <= 16'd16384;
      cfg_q.inverse_scale   <= 16'd4096;
      cfg_q.pad_left        <= '0;
      cfg_q.pad_top         <= '0;
      cfg_q.image_width     <= 13'd640;
      cfg_q.image_height    <= 13'd640;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/dhd_argmax.sv
// dhd_argmax: running best class score over one anchor's words.
// Depends on dhd_pkg.
module dhd_argmax #(
  parameter int unsigned NUM_CLASSES = 80
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [dhd_pkg::ScoreW-1:0]   score_i,
  input  logic                         last_i,
  input  logic [dhd_pkg::ScoreW-1:0]   threshold_i,
  output logic                         final_o,
  output dhd_pkg::dhd_anchor_t         anchor_o
);

  localparam logic [dhd_pkg::ClassW:0] NumCls = (dhd_pkg::ClassW+1)'(NUM_CLASSES);

  logic [dhd_pkg::ScoreW-1:0] best_q, best_d, best_n;
  logic [dhd_pkg::ClassW-1:0] class_q, class_d, class_n;
  logic [dhd_pkg::ClassW-1:0] cnt_q, cnt_d;
  logic [dhd_pkg::ClassW:0]   cnt_inc;
  logic                       gt;

  assign gt      = score_i > best_q;   // strict: an equal later score keeps the earlier class
  assign best_n  = gt ? score_i : best_q;
  assign class_n = gt ? cnt_q : class_q;
  assign cnt_inc = {1'b0, cnt_q} + 1'b1;
  assign final_o = last_i || (cnt_inc >= NumCls);

  assign anchor_o.keep     = final_o && (best_n >= threshold_i);
  assign anchor_o.class_id = class_n;
  assign anchor_o.best     = best_n;

  always_comb begin
    best_d  = best_q;
    class_d = class_q;
    cnt_d   = cnt_q;
    if (accept_i) begin
      if (final_o) begin
        best_d  = '0;
        class_d = '0;
        cnt_d   = '0;
      end else begin
        best_d  = best_n;
        class_d = class_n;
        cnt_d   = cnt_inc[dhd_pkg::ClassW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= '0;
      class_q <= '0;
      cnt_q   <= '0;
    end else begin
      best_q  <= best_d;
      class_q <= class_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/dhd_corner.sv
// dhd_corner: scales one model-space corner to image space and clamps it.
// Two register stages: product, then clamped Q.17 value. Depends on dhd_pkg.
module dhd_corner (
  input  logic                          clk_i,
  input  logic                          mul_en_i,
  input  logic                          clamp_en_i,
  input  logic [dhd_pkg::CornerW-1:0]   corner_i,
  input  logic [15:0]                   scale_i,
  input  logic [dhd_pkg::CoordW-1:0]    limit_i,
  output logic [dhd_pkg::ClampW-1:0]    clamped_o
);

  logic signed [dhd_pkg::ProdW-1:0] prod_q, prod_d;
  logic [dhd_pkg::ClampW-1:0]       hi;
  logic [dhd_pkg::ClampW-1:0]       clamp_q, clamp_d;

  assign prod_d = $signed(corner_i) * $signed({1'b0, scale_i});
  assign hi     = {limit_i, {dhd_pkg::FracShift{1'b0}}};

  always_comb begin
    if (prod_q[dhd_pkg::ProdW-1]) begin
      clamp_d = '0;
    end else if (prod_q[dhd_pkg::ProdW-2:0] > (dhd_pkg::ProdW-1)'(hi)) begin
      clamp_d = hi;
    end else begin
      clamp_d = prod_q[dhd_pkg::ClampW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
    if (clamp_en_i) begin
      clamp_q <= clamp_d;
    end
  end

  assign clamped_o = clamp_q;

endmodule

FILE: hw/rtl/detection_head_decode.sv
// detection_head_decode: per-anchor argmax, threshold and box decode to image pixels.
// Path from the accepting edge to the result word: corners registered at that edge, then
// the multiply, clamp and result registers. Throughput: one word per cycle, each
// stage moves on when the next is empty or draining. Reset clears the argmax state and the
// pipeline and loads the register defaults. Depends on dhd_pkg, dhd_cfg, dhd_argmax, dhd_corner.
module detection_head_decode #(
  parameter int unsigned NUM_CLASSES = 80
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  dhd_pkg::dhd_in_t             in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output dhd_pkg::dhd_out_t            out_word_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dhd_pkg::CfgAddrW-1:0] paddr,
  input  logic [dhd_pkg::CfgDataW-1:0] pwdata,
  output logic [dhd_pkg::CfgDataW-1:0] prdata,
  output logic                         pready
);

  localparam int unsigned CW = dhd_pkg::CornerW;

  dhd_pkg::dhd_cfg_t    cfg;
  dhd_pkg::dhd_anchor_t anchor;
  logic                 final_w;
  logic                 accept;

  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  logic [dhd_pkg::CoordW-1:0] lim_x, lim_y;
  logic [CW-1:0] cx2, cy2, bw, bh, padx, pady;
  logic [CW-1:0] x1_d, y1_d, x2_d, y2_d;
  logic [CW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [dhd_pkg::ClampW-1:0] x1_c, y1_c, x2_c, y2_c;
  logic degenerate;

  logic [dhd_pkg::ClassW-1:0] cls1_q, cls2_q, cls3_q;
  logic [dhd_pkg::ScoreW-1:0] best1_q, best2_q, best3_q;
  dhd_pkg::dhd_out_t          out_q;

  dhd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage handshake, bubbles collapse
  assign adv4       = !v4_q || !out_stall_i;
  assign adv3       = !v3_q || adv4;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;
  assign accept     = in_valid_i && adv1;

  dhd_argmax #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_argmax (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .score_i     (in_word_i.class_score),
    .last_i      (in_word_i.last_class),
    .threshold_i (cfg.score_threshold),
    .final_o     (final_w),
    .anchor_o    (anchor)
  );

  // clamp limit: size-1, 0 for a zero size, saturating at the coordinate max
  always_comb begin
    if (cfg.image_width == '0) begin
      lim_x = '0;
    end else if (cfg.image_width > {1'b0, dhd_pkg::CoordMax}) begin
      lim_x = dhd_pkg::CoordMax;
    end else begin
      lim_x = dhd_pkg::CoordW'(cfg.image_width - 1'b1);
    end
    if (cfg.image_height == '0) begin
      lim_y = '0;
    end else if (cfg.image_height > {1'b0, dhd_pkg::CoordMax}) begin
      lim_y = dhd_pkg::CoordMax;
    end else begin
      lim_y = dhd_pkg::CoordW'(cfg.image_height - 1'b1);
    end
  end

  // corners in Q.5: 2*centre -/+ size - pad*32
  assign cx2  = {in_word_i.centre_x[15], in_word_i.centre_x, 1'b0};
  assign cy2  = {in_word_i.centre_y[15], in_word_i.centre_y, 1'b0};
  assign bw   = {{2{in_word_i.box_width[15]}}, in_word_i.box_width};
  assign bh   = {{2{in_word_i.box_height[15]}}, in_word_i.box_height};
  assign padx = {3'b000, cfg.pad_left, 5'b00000};
  assign pady = {3'b000, cfg.pad_top, 5'b00000};
  assign x1_d = cx2 - bw - padx;
  assign x2_d = cx2 + bw - padx;
  assign y1_d = cy2 - bh - pady;
  assign y2_d = cy2 + bh - pady;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      x1_q    <= x1_d;
      x2_q    <= x2_d;
      y1_q    <= y1_d;
      y2_q    <= y2_d;
      cls1_q  <= anchor.class_id;
      best1_q <= anchor.best;
    end
    if (adv2) begin
      cls2_q  <= cls1_q;
      best2_q <= best1_q;
    end
    if (adv3) begin
      cls3_q  <= cls2_q;
      best3_q <= best2_q;
    end
    if (adv4) begin
      out_q.class_id   <= cls3_q;
      out_q.best_score <= best3_q;
      out_q.left       <= x1_c[dhd_pkg::ClampW-1:dhd_pkg::FracShift];
      out_q.top        <= y1_c[dhd_pkg::ClampW-1:dhd_pkg::FracShift];
      out_q.right      <= x2_c[dhd_pkg::ClampW-1:dhd_pkg::FracShift];
      out_q.bottom     <= y2_c[dhd_pkg::ClampW-1:dhd_pkg::FracShift];
    end
  end

  dhd_corner u_x1 (
    .clk_i (clk_i), .mul_en_i (adv2), .clamp_en_i (adv3), .corner_i (x1_q),
    .scale_i (cfg.inverse_scale), .limit_i (lim_x), .clamped_o (x1_c)
  );
  dhd_corner u_y1 (
    .clk_i (clk_i), .mul_en_i (adv2), .clamp_en_i (adv3), .corner_i (y1_q),
    .scale_i (cfg.inverse_scale), .limit_i (lim_y), .clamped_o (y1_c)
  );
  dhd_corner u_x2 (
    .clk_i (clk_i), .mul_en_i (adv2), .clamp_en_i (adv3), .corner_i (x2_q),
    .scale_i (cfg.inverse_scale), .limit_i (lim_x), .clamped_o (x2_c)
  );
  dhd_corner u_y2 (
    .clk_i (clk_i), .mul_en_i (adv2), .clamp_en_i (adv3), .corner_i (y2_q),
    .scale_i (cfg.inverse_scale), .limit_i (lim_y), .clamped_o (y2_c)
  );

  // box with no extent after clamping is dropped
  assign degenerate = (x2_c <= x1_c) || (y2_c <= y1_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= accept && final_w && anchor.keep;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q && !degenerate;
    end
  end

  assign out_valid_o = v4_q;
  assign out_word_o  = out_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_corners_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.right >= out_word_o.left) &&
                    (out_word_o.bottom >= out_word_o.top))
    else $error("result word has inverted corners");

  a_class_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_word_o.class_id) < NUM_CLASSES))
    else $error("class id beyond the class count");

endmodule
